[rtl/gda_pkg.sv]
// Package for the Gregorian date unit: widths, defaults, mode codes and calendar helpers.
`timescale 1ns / 1ps
`default_nettype none
package gda_pkg;

  localparam int unsigned MaxYearDefault   = 9999;
  localparam int unsigned EpochYearDefault = 1900;

  // Working year width; holds any MAX_YEAR up to 65535
  localparam int unsigned YearW = 16;
  localparam int unsigned OffW  = 22;

  // Request kinds
  localparam logic [1:0] ModeAdd  = 2'd0;
  localparam logic [1:0] ModeSub  = 2'd1;
  localparam logic [1:0] ModeDiff = 2'd2;
  localparam logic [1:0] ModeWday = 2'd3;

  // Status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StInvalid = 2'd1;
  localparam logic [1:0] StOrder   = 2'd2;
  localparam logic [1:0] StRange   = 2'd3;

  // Leap test from the low year bits and the year modulo 400
  function automatic logic is_leap(input logic [1:0] ylo, input logic [8:0] y400);
    is_leap = (ylo == 2'd0) && (y400 != 9'd100) && (y400 != 9'd200) && (y400 != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    month_len = len;
  endfunction

  // Reduce a value below 42 modulo 7
  function automatic logic [2:0] mod7(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (r >= 6'd35) r = r - 6'd35;
    else if (r >= 6'd28) r = r - 6'd28;
    else if (r >= 6'd21) r = r - 6'd21;
    else if (r >= 6'd14) r = r - 6'd14;
    else if (r >= 6'd7) r = r - 6'd7;
    mod7 = r[2:0];
  endfunction

endpackage
`default_nettype wire

[rtl/gregorian_date_arithmetic.sv]
// Gregorian date unit: add/subtract days, day difference and weekday by month walking.
//
// One request is taken at a time. The year of each date is first reduced modulo 400
// by repeated subtraction, one date after the other, then the dates are checked, then
// a single month-length adder walks one calendar month per cycle: add and subtract
// walk from the first date until the offset is used up or the result leaves years
// 0..MAX_YEAR, difference walks the months between the dates and weekday the months
// since EPOCH_YEAR-01-01. The day difference saturates at the top of its field. The
// result sits in an output register, so a new request can be taken while the previous
// result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
module gregorian_date_arithmetic #(
  parameter int unsigned MAX_YEAR   = gda_pkg::MaxYearDefault,
  parameter int unsigned EPOCH_YEAR = gda_pkg::EpochYearDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // first_day, first_month, first_year, second_day, second_month, second_year, day_offset
  input  wire  [71:0] s_axis_tdata,
  // mode
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // result_day, result_month, result_year, day_difference, weekday, first_is_leap
  output logic [55:0] m_axis_tdata,
  // status
  output logic [1:0]  m_axis_tuser
);
  import gda_pkg::*;

  localparam logic [YearW-1:0] MaxY   = YearW'(MAX_YEAR);
  localparam logic [YearW-1:0] EpochY = YearW'(EPOCH_YEAR);
  localparam logic [8:0]       Epoch400 = 9'(EPOCH_YEAR % 400);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RED1  = 3'd1;
  localparam logic [2:0] S_RED2  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [1:0]  mode_q, mode_d;
  logic [4:0]  d1_q, d1_d, d2_q, d2_d;
  logic [3:0]  m1_q, m1_d, m2_q, m2_d;
  logic [13:0] y1_q, y1_d, y2_q, y2_d;
  logic [13:0] red_q, red_d;
  logic [8:0]  r1_q, r1_d, r2_q, r2_d;
  logic [OffW-1:0] rem_q, rem_d, acc_q, acc_d;
  logic [4:0]  cd_q, cd_d;
  logic [3:0]  cm_q, cm_d;
  logic [YearW-1:0] cy_q, cy_d;
  logic [8:0]  c400_q, c400_d;
  logic [2:0]  w_q, w_d;
  logic [1:0]  st_q, st_d;
  logic        ovalid_q, ovalid_d;
  logic [55:0] odata_q, odata_d;
  logic [1:0]  ouser_q, ouser_d;

  // Calendar terms used by the check and the walk
  logic        leap1, leap2, ok1, ok2, cleap, pleap;
  logic [4:0]  clen, plen, left;
  logic [3:0]  pm;
  logic [YearW-1:0] py;
  logic [8:0]  p400;
  logic [4:0]  step;
  logic [OffW:0] acc_sum;

  always_comb begin
    leap1 = is_leap(y1_q[1:0], r1_q);
    leap2 = is_leap(y2_q[1:0], r2_q);
    ok1   = (m1_q >= 4'd1) && (m1_q <= 4'd12) && (d1_q >= 5'd1) &&
            (d1_q <= month_len(m1_q, leap1));
    ok2   = (m2_q >= 4'd1) && (m2_q <= 4'd12) && (d2_q >= 5'd1) &&
            (d2_q <= month_len(m2_q, leap2));
    cleap = is_leap(cy_q[1:0], c400_q);
    clen  = month_len(cm_q, cleap);
    left  = clen - cd_q;
    step  = left + 5'd1;
    // previous month, for the backward walk
    if (cm_q == 4'd1) begin
      pm   = 4'd12;
      py   = cy_q - YearW'(1);
      p400 = (c400_q == 9'd0) ? 9'd399 : c400_q - 9'd1;
    end else begin
      pm   = cm_q - 4'd1;
      py   = cy_q;
      p400 = c400_q;
    end
    pleap = is_leap(py[1:0], p400);
    plen  = month_len(pm, pleap);
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    mode_d = mode_q;
    d1_d = d1_q; m1_d = m1_q; y1_d = y1_q;
    d2_d = d2_q; m2_d = m2_q; y2_d = y2_q;
    red_d = red_q; r1_d = r1_q; r2_d = r2_q;
    rem_d = rem_q; acc_d = acc_q; w_d = w_q; st_d = st_q;
    cd_d = cd_q; cm_d = cm_q; cy_d = cy_q; c400_d = c400_q;
    ovalid_d = ovalid_q; odata_d = odata_q; ouser_d = ouser_q;
    acc_sum = '0;

    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d = s_axis_tuser;
          d1_d = s_axis_tdata[4:0];   m1_d = s_axis_tdata[8:5];   y1_d = s_axis_tdata[22:9];
          d2_d = s_axis_tdata[27:23]; m2_d = s_axis_tdata[31:28]; y2_d = s_axis_tdata[45:32];
          rem_d = s_axis_tdata[67:46];
          red_d = s_axis_tdata[22:9];
          st_d = StOk;
          state_d = S_RED1;
        end
      end
      S_RED1: begin
        if (red_q >= 14'd400) red_d = red_q - 14'd400;
        else begin
          r1_d = red_q[8:0];
          red_d = y2_q;
          state_d = S_RED2;
        end
      end
      S_RED2: begin
        if (red_q >= 14'd400) red_d = red_q - 14'd400;
        else begin
          r2_d = red_q[8:0];
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        acc_d = '0;
        w_d = 3'd0;
        cd_d = d1_q; cm_d = m1_q; cy_d = YearW'(y1_q); c400_d = r1_q;
        state_d = S_WALK;
        if (!ok1 || (mode_q == ModeDiff && !ok2)) begin
          st_d = StInvalid;
          state_d = S_OUT;
        end else if (YearW'(y1_q) > MaxY || (mode_q == ModeDiff && YearW'(y2_q) > MaxY)) begin
          st_d = StRange;
          state_d = S_OUT;
        end else if (mode_q == ModeDiff) begin
          if ({y1_q, m1_q, d1_q} < {y2_q, m2_q, d2_q}) begin
            st_d = StOrder;
            state_d = S_OUT;
          end else begin
            cd_d = d2_q; cm_d = m2_q; cy_d = YearW'(y2_q); c400_d = r2_q;
          end
        end else if (mode_q == ModeWday) begin
          if (YearW'(y1_q) < EpochY) begin
            st_d = StOrder;
            state_d = S_OUT;
          end else begin
            cd_d = 5'd1; cm_d = 4'd1; cy_d = EpochY; c400_d = Epoch400;
            w_d = 3'd1;
          end
        end
      end
      S_WALK: begin
        case (mode_q)
          ModeAdd: begin
            if (rem_q <= OffW'(left)) begin
              cd_d = cd_q + rem_q[4:0];
              state_d = S_OUT;
            end else if (cm_q == 4'd12 && cy_q >= MaxY) begin
              st_d = StRange;
              state_d = S_OUT;
            end else begin
              rem_d = rem_q - OffW'(step);
              cd_d = 5'd1;
              if (cm_q == 4'd12) begin
                cm_d = 4'd1;
                cy_d = cy_q + YearW'(1);
                c400_d = (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
              end else cm_d = cm_q + 4'd1;
            end
          end
          ModeSub: begin
            if (rem_q < OffW'(cd_q)) begin
              cd_d = cd_q - rem_q[4:0];
              state_d = S_OUT;
            end else if (cm_q == 4'd1 && cy_q == '0) begin
              st_d = StRange;
              state_d = S_OUT;
            end else begin
              rem_d = rem_q - OffW'(cd_q);
              cm_d = pm; cy_d = py; c400_d = p400; cd_d = plen;
            end
          end
          default: begin
            // difference and weekday: count days up to the first date, count saturates
            if (cy_q == YearW'(y1_q) && cm_q == m1_q) begin
              acc_sum = {1'b0, acc_q} + (OffW+1)'(d1_q - cd_q);
              acc_d = acc_sum[OffW] ? '1 : acc_sum[OffW-1:0];
              w_d = mod7(6'(w_q) + 6'(d1_q - cd_q));
              state_d = S_OUT;
            end else begin
              acc_sum = {1'b0, acc_q} + (OffW+1)'(step);
              acc_d = acc_sum[OffW] ? '1 : acc_sum[OffW-1:0];
              w_d = mod7(6'(w_q) + 6'(step));
              cd_d = 5'd1;
              if (cm_q == 4'd12) begin
                cm_d = 4'd1;
                cy_d = cy_q + YearW'(1);
                c400_d = (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
              end else cm_d = cm_q + 4'd1;
            end
          end
        endcase
      end
      S_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          ouser_d = st_q;
          odata_d = '0;
          odata_d[48] = leap1;
          if (st_q == StOk) begin
            case (mode_q)
              ModeAdd, ModeSub: begin
                odata_d[4:0] = cd_q;
                odata_d[8:5] = cm_q;
                odata_d[22:9] = cy_q[13:0];
              end
              ModeDiff: odata_d[44:23] = acc_q;
              default: odata_d[47:45] = w_q + 3'd1;
            endcase
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    d1_q <= d1_d; m1_q <= m1_d; y1_q <= y1_d;
    d2_q <= d2_d; m2_q <= m2_d; y2_q <= y2_d;
    red_q <= red_d; r1_q <= r1_d; r2_q <= r2_d;
    rem_q <= rem_d; acc_q <= acc_d; w_q <= w_d; st_q <= st_d;
    cd_q <= cd_d; cm_q <= cm_d; cy_q <= cy_d; c400_q <= c400_d;
    odata_q <= odata_d; ouser_q <= ouser_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

endmodule
`default_nettype wire
